/* rtl/fbc64_pkg.sv */
// ----------------------------------------------------------------------------
// fbc64_pkg: shared types, constants and round function
// Constants and helpers for the 64-bit Feistel block cipher core.
// ----------------------------------------------------------------------------
package fbc64_pkg;

    localparam int HALF_BITS      = 32;
    localparam int BLOCK_BITS     = 2 * HALF_BITS;
    localparam int ROT_LEFT       = 6;
    localparam int KEY_SLOTS      = 8;
    localparam int KEY_IDX_W      = $clog2(KEY_SLOTS);
    localparam int CFG_IDX_W      = KEY_IDX_W + 1;
    localparam int ROUND_COUNT_DEF = 8;

    // command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [HALF_BITS-1:0] t_half;

    // control that travels along with each block
    typedef struct packed {
        logic valid;
        logic cmd;
    } t_ctrl;

    // rotl(half, 6) xor key
    function automatic t_half round_mix(input t_half half, input t_half key);
        round_mix = (half << ROT_LEFT) ^ (half >> (HALF_BITS - ROT_LEFT)) ^ key;
    endfunction

endpackage

/* rtl/fbc64_round.sv */
// ----------------------------------------------------------------------------
// fbc64_round: one registered Feistel round
// Computes (L, R) <- (R ^ rotl(L, 6) ^ key, L) and registers the result.
// ----------------------------------------------------------------------------
module fbc64_round
    import fbc64_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_half i_left,
    input  t_half i_right,
    input  t_half i_key,
    output t_ctrl o_ctrl,
    output t_half o_left,
    output t_half o_right
);

    t_ctrl r_ctrl;
    t_half r_left;
    t_half r_right;
    t_half n_left;

    // round function
    assign n_left = i_right ^ round_mix(i_left, i_key);

    // control: reset clears valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= i_left;
    end

    assign o_ctrl  = r_ctrl;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

/* rtl/feistel_block_cipher_64_core.sv */
// ----------------------------------------------------------------------------
// feistel_block_cipher_64_core: pipelined 64-bit Feistel block cipher
// Encrypts or decrypts one 64-bit block per cycle through one stage per round.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. busy is always low, so a block may enter every cycle. command 0
//   encrypts (keys 0 up), 1 decrypts (keys ROUND_COUNT-1 down to 0).
//   Output: o_done is high for one cycle with o_block_out; the receiver
//   cannot stall, and the pipeline never needs to.
//   Path from start to o_done: input register, one register stage per
//   round, output register.
//   Throughput: one block per cycle, set by the one-round-per-stage pipe.
//   Config: i_cfg_index 0..7 selects round_key_0..7, written when
//   i_cfg_valid and o_cfg_ready are high; o_cfg_ready is always high and
//   indexes past seven are ignored. Write keys only while the pipe is empty.
//   Reset (synchronous, active low): all keys go to zero and every block in
//   flight is dropped.
// ----------------------------------------------------------------------------
module feistel_block_cipher_64_core
    import fbc64_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [BLOCK_BITS-1:0] i_block_in,
    output logic                  o_done,
    output logic [BLOCK_BITS-1:0] o_block_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [HALF_BITS-1:0]  i_cfg_data
);

    localparam int LATENCY = ROUND_COUNT + 2;

    t_half                 r_keys [KEY_SLOTS];
    t_ctrl                 stg_ctrl  [ROUND_COUNT+1];
    t_half                 stg_left  [ROUND_COUNT+1];
    t_half                 stg_right [ROUND_COUNT+1];
    t_ctrl                 r_in_ctrl;
    t_half                 r_in_left;
    t_half                 r_in_right;
    logic                  r_done;
    logic [BLOCK_BITS-1:0] r_block_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '{default: '0};
        end else if (i_cfg_valid && o_cfg_ready && !i_cfg_index[CFG_IDX_W-1]) begin
            r_keys[i_cfg_index[KEY_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctrl <= '0;
        end else begin
            r_in_ctrl.valid <= start && !busy;
            r_in_ctrl.cmd   <= i_command;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_left  <= i_block_in[BLOCK_BITS-1:HALF_BITS];
        r_in_right <= i_block_in[HALF_BITS-1:0];
    end

    assign stg_ctrl[0]  = r_in_ctrl;
    assign stg_left[0]  = r_in_left;
    assign stg_right[0] = r_in_right;

    // one stage per round; key order follows the command bit
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        localparam int ENC_IDX = g;
        localparam int DEC_IDX = ROUND_COUNT - 1 - g;
        t_half key;

        assign key = (stg_ctrl[g].cmd == CMD_DECRYPT) ? r_keys[DEC_IDX]
                                                      : r_keys[ENC_IDX];

        fbc64_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (stg_ctrl[g]),
            .i_left  (stg_left[g]),
            .i_right (stg_right[g]),
            .i_key   (key),
            .o_ctrl  (stg_ctrl[g+1]),
            .o_left  (stg_left[g+1]),
            .o_right (stg_right[g+1])
        );
    end

    // output register: final R high, final L low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= stg_ctrl[ROUND_COUNT].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block_out <= {stg_right[ROUND_COUNT], stg_left[ROUND_COUNT]};
    end

    assign o_done      = r_done;
    assign o_block_out = r_block_out;

    // every result must come from a block taken earlier with start high and busy low
    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input transaction");

    // every accepted block produces a result
    a_start_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("input transaction produced no result");

    // o_done follows the last round stage's valid in the next cycle
    a_out_follows_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stg_ctrl[ROUND_COUNT].valid |=> o_done)
        else $error("output strobe lost after last round");

endmodule
